[sv/cdt_pkg.sv]
// Package with the shared types, codes and widths of the countdown timer.
`timescale 1ns / 1ps

package cdt_pkg;

   localparam int CntWidth  = 32;
   localparam int DataWidth = 32;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_CTRL   = 3'd0,
      REG_LOAD   = 3'd1,
      REG_COUNT  = 3'd2,
      REG_MASK   = 3'd3,
      REG_STATUS = 3'd4,
      REG_CLEAR  = 3'd5,
      REG_HIGH   = 3'd6,
      REG_LOW    = 3'd7
   } reg_addr_type;

   typedef enum logic {
      CSR_PERIODIC = 1'b0,
      CSR_PWM_ALT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [2:0]           reg_addr;
      logic [DataWidth-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 irq;
      logic                 pwm_level;
   } rsp_item_type;

   typedef struct packed {
      logic periodic_mode;
      logic pwm_alternate;
   } cfg_type;

endpackage

[sv/cdt_if.sv]
// Request and response channel interfaces of the countdown timer.
`timescale 1ns / 1ps

interface cdt_req_if
   import cdt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [2:0]           reg_addr;
   logic [DataWidth-1:0] write_data;

   modport source (output valid, output mode, output reg_addr, output write_data,
                   input ready);
   modport sink (input valid, input mode, input reg_addr, input write_data,
                 output ready);
endinterface

interface cdt_rsp_if
   import cdt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] read_data;
   logic                 irq;
   logic                 pwm_level;

   modport source (output valid, output read_data, output irq, output pwm_level,
                   input ready);
   modport sink (input valid, input read_data, input irq, input pwm_level,
                 output ready);
endinterface

[sv/cdt_core.sv]
// Timer register bank: tick, register write and register read handling.
`timescale 1ns / 1ps

module cdt_core
   import cdt_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
   );

   logic                running_ff, running_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [CntWidth-1:0] load_ff, load_in;
   logic                mask_ff, mask_in;
   logic                flag_ff, flag_in;
   logic [CntWidth-1:0] high_ff, high_in;
   logic [CntWidth-1:0] low_ff, low_in;
   logic                level_ff, level_in;
   logic [CntWidth-1:0] read_value;

   always_comb begin
      running_in = running_ff;
      count_in   = count_ff;
      load_in    = load_ff;
      mask_in    = mask_ff;
      flag_in    = flag_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      level_in   = level_ff;
      read_value = '0;
      case (item.mode)
         MODE_TICK: begin
            if (running_ff) begin
               if (count_ff > CntWidth'(1)) begin
                  count_in = count_ff - CntWidth'(1);
               end else begin
                  flag_in = 1'b1;
                  if (cfg.pwm_alternate) begin
                     level_in = !level_ff;
                     load_in  = level_in ? high_ff : low_ff;
                     count_in = load_in;
                  end else if (cfg.periodic_mode) begin
                     count_in = load_ff;
                  end else begin
                     count_in   = '0;
                     running_in = 1'b0;
                  end
               end
            end
         end
         MODE_WRITE: begin
            case (item.reg_addr)
               REG_CTRL:  running_in = item.write_data[0];
               REG_LOAD: begin
                  load_in  = CntWidth'(item.write_data);
                  count_in = CntWidth'(item.write_data);
               end
               REG_MASK:  mask_in = item.write_data[0];
               REG_CLEAR: begin
                  if (item.write_data[0]) begin
                     flag_in = 1'b0;
                  end
               end
               REG_HIGH:  high_in = CntWidth'(item.write_data);
               REG_LOW:   low_in = CntWidth'(item.write_data);
               default: ;
            endcase
         end
         MODE_READ: begin
            case (item.reg_addr)
               REG_CTRL:   read_value = CntWidth'(running_ff);
               REG_LOAD:   read_value = load_ff;
               REG_COUNT:  read_value = count_ff;
               REG_MASK:   read_value = CntWidth'(mask_ff);
               REG_STATUS: read_value = CntWidth'(flag_ff);
               REG_HIGH:   read_value = high_ff;
               REG_LOW:    read_value = load_ff - count_ff;
               default:    read_value = '0;
            endcase
         end
         default: ;
      endcase
   end

   assign result.read_data = DataWidth'(read_value);
   assign result.irq       = flag_in & mask_in;
   assign result.pwm_level = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff   <= '0;
         load_ff    <= '0;
         mask_ff    <= 1'b0;
         flag_ff    <= 1'b0;
         high_ff    <= '0;
         low_ff     <= '0;
         level_ff   <= 1'b0;
      end else if (fire) begin
         running_ff <= running_in;
         count_ff   <= count_in;
         load_ff    <= load_in;
         mask_ff    <= mask_in;
         flag_ff    <= flag_in;
         high_ff    <= high_in;
         low_ff     <= low_in;
         level_ff   <= level_in;
      end
   end

endmodule

[sv/countdown_timer_with_pwm_toggle.sv]
// Top level of the countdown timer with input stage, result stage and mode bits.
//
// Channel   Direction  Payload
// req_ch    in         mode, reg_addr, write_data
// rsp_ch    out        read_data, irq, pwm_level
// csr_*     in         csr_addr selects periodic_mode or pwm_alternate
//
// One request per cycle is sustained while rsp_ch.ready is high.
// A request passes the input register and then the result register before its response is offered.
// While a finished response is stalled, the input register accepts a new request only if it is empty.
// Reset is synchronous and clears all timer state and both mode bits.
`timescale 1ns / 1ps

module countdown_timer_with_pwm_toggle
   import cdt_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   cdt_req_if.sink    req_ch,
   cdt_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic       csr_wdata
   );

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   cfg_type      cfg_ff;
   logic         can_advance;
   logic         fire;
   rsp_item_type result;

   assign can_advance  = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && can_advance;
   assign req_ch.ready = !in_valid_ff || can_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PERIODIC: cfg_ff.periodic_mode <= csr_wdata;
            CSR_PWM_ALT:  cfg_ff.pwm_alternate <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.mode       <= req_ch.mode;
         in_item_ff.reg_addr   <= req_ch.reg_addr;
         in_item_ff.write_data <= req_ch.write_data;
      end
   end

   cdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (can_advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_item_ff.read_data;
   assign rsp_ch.irq       = out_item_ff.irq;
   assign rsp_ch.pwm_level = out_item_ff.pwm_level;

endmodule

[sv/cdt_checker.sv]
// Port-level checks of the countdown timer and their binding to the top level.
`timescale 1ns / 1ps

module cdt_port_checker
   import cdt_pkg::*;
   (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DataWidth-1:0] rsp_read_data,
   input logic                 rsp_irq,
   input logic                 rsp_pwm_level
   );

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_irq) && $stable(rsp_pwm_level))
      else $error("stalled response changed");

   // With no response pending, the pipeline can always take a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response stage");

   // A request transfer is followed by a valid response after the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("response missing after request transfer");

   // No response comes out of reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind countdown_timer_with_pwm_toggle cdt_port_checker u_cdt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_irq       (rsp_ch.irq),
   .rsp_pwm_level (rsp_ch.pwm_level)
);
